### sv/alfr_pkg.sv
// Shared types, constants and control-store program for the additive lagged-Fibonacci generator.
`default_nettype none

package alfr_pkg;

  // Item operation codes
  localparam logic OP_SEED = 1'b0;
  localparam logic OP_DRAW = 1'b1;

  // Park-Miller seeding constants, modulus 2^31-1
  localparam logic [14:0] PM_MULT       = 15'd16807;
  localparam logic [30:0] PM_MOD        = 31'h7FFF_FFFF;
  localparam int          WARMUP_ROUNDS = 10;
  localparam int          PROD_W        = 46;

  // Micro-program addresses
  typedef logic [3:0] upc_t;
  localparam upc_t UA_IDLE      = 4'd0;
  localparam upc_t UA_SEED_W0   = 4'd1;
  localparam upc_t UA_SEED_MUL  = 4'd2;
  localparam upc_t UA_SEED_RED  = 4'd3;
  localparam upc_t UA_WARM_INIT = 4'd4;
  localparam upc_t UA_WARM_RD   = 4'd5;
  localparam upc_t UA_WARM_ADD  = 4'd6;
  localparam upc_t UA_SEED_DONE = 4'd7;
  localparam upc_t UA_DRAW_ADD  = 4'd8;

  // Word store write source
  typedef enum logic [1:0] {
    WS_NONE,
    WS_SEED,
    WS_FOLD,
    WS_SUM
  } wsrc_t;

  // Sequencing mode of a control word
  typedef enum logic [2:0] {
    SQ_NEXT,
    SQ_JUMP,
    SQ_DISPATCH,
    SQ_LOOP_IDX,
    SQ_LOOP_CNT,
    SQ_PEND,
    SQ_WAIT_OUT
  } seq_t;

  // One control word
  typedef struct packed {
    logic  take_in;
    wsrc_t wsrc;
    logic  mul_en;
    logic  idx_set;
    logic  idx_inc;
    logic  ptr_init;
    logic  ptr_adv;
    logic  cnt_clr;
    logic  cnt_inc;
    logic  set_seeded;
    logic  out_load;
    seq_t  seq;
    upc_t  target;
  } ctl_t;

  // Control store: one word per micro-program step
  function automatic ctl_t ucode(input upc_t a);
    ctl_t c;
    c = '0;
    c.wsrc = WS_NONE;
    c.seq  = SQ_NEXT;
    unique case (a)
      UA_IDLE: begin
        c.take_in = 1'b1;
        c.seq     = SQ_DISPATCH;
        c.target  = UA_DRAW_ADD;
      end
      UA_SEED_W0: begin
        c.wsrc    = WS_SEED;
        c.idx_set = 1'b1;
      end
      UA_SEED_MUL: begin
        c.mul_en = 1'b1;
      end
      UA_SEED_RED: begin
        c.wsrc    = WS_FOLD;
        c.idx_inc = 1'b1;
        c.seq     = SQ_LOOP_IDX;
        c.target  = UA_SEED_MUL;
      end
      UA_WARM_INIT: begin
        c.ptr_init = 1'b1;
        c.cnt_clr  = 1'b1;
      end
      UA_WARM_RD: begin
        c.seq = SQ_NEXT;
      end
      UA_WARM_ADD: begin
        c.wsrc    = WS_SUM;
        c.ptr_adv = 1'b1;
        c.cnt_inc = 1'b1;
        c.seq     = SQ_LOOP_CNT;
        c.target  = UA_WARM_RD;
      end
      UA_SEED_DONE: begin
        c.set_seeded = 1'b1;
        c.seq        = SQ_PEND;
        c.target     = UA_IDLE;
      end
      UA_DRAW_ADD: begin
        c.wsrc     = WS_SUM;
        c.ptr_adv  = 1'b1;
        c.out_load = 1'b1;
        c.seq      = SQ_WAIT_OUT;
        c.target   = UA_IDLE;
      end
      default: begin
        c.seq    = SQ_JUMP;
        c.target = UA_IDLE;
      end
    endcase
    return c;
  endfunction

  // Map a 32-bit signed word to its residue mod 2^31-1 (-2^31 maps to 2^31-2)
  function automatic logic [30:0] pm_prep(input logic [31:0] w);
    logic [30:0] r;
    if (!w[31]) begin
      r = w[30:0];
    end else if (w[30:0] == '0) begin
      r = PM_MOD - 31'd1;
    end else begin
      r = w[30:0] - 31'd1;
    end
    return r;
  endfunction

  // Reduce a 46-bit product mod 2^31-1 by folding the high part
  function automatic logic [30:0] pm_fold(input logic [PROD_W-1:0] p);
    logic [31:0] s;
    s = {17'd0, p[PROD_W-1:31]} + {1'b0, p[30:0]};
    if (s >= {1'b0, PM_MOD}) begin
      s = s - {1'b0, PM_MOD};
    end
    return s[30:0];
  endfunction

endpackage

`default_nettype wire

### sv/alfr_ram.sv
// Generic RAM: one write port, two read ports with registered read data.
`default_nettype none

module alfr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 31
) (
  input  wire logic                               clk,
  input  wire logic                               we,
  input  wire logic [((DEPTH>1)?$clog2(DEPTH):1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                   wdata,
  input  wire logic [((DEPTH>1)?$clog2(DEPTH):1)-1:0] raddr_a,
  output logic      [WIDTH-1:0]                   rdata_a,
  input  wire logic [((DEPTH>1)?$clog2(DEPTH):1)-1:0] raddr_b,
  output logic      [WIDTH-1:0]                   rdata_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read ports
  always_ff @(posedge clk) begin
    rdata_a <= mem_r[raddr_a];
    rdata_b <= mem_r[raddr_b];
  end

endmodule

`default_nettype wire

### sv/additive_lagged_fibonacci_rng.sv
// Top level of the additive lagged-Fibonacci generator: micro-sequencer, datapath, word RAM.
//
//   channel  | ports                                   | direction
//   ---------+-----------------------------------------+----------
//   input    | in_valid, in_ready, in_operation,       | in
//            | in_seed_value                           |
//   result   | out_valid, out_ready, out_random_value  | out
//
// A seeded draw runs a dispatch step, then an add and write-back step; the add
// step waits for the word RAM's registered read of the front and rear words.
// A seed runs 30 multiply/reduce pairs, then 310 read/add pairs.
// A draw before any seed first runs the seed program with seed one and yields one beat.
// Reset (rst_n low, synchronous) sets front 3, rear 0, unseeded; no clear pass.
// The draw's add step holds while a finished beat waits in the output register.
`default_nettype none

module additive_lagged_fibonacci_rng
  import alfr_pkg::*;
#(
  parameter int STATE_WORDS    = 31,
  parameter int LAG_SEPARATION = 3
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_operation,
  input  wire logic [31:0] in_seed_value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic      [30:0] out_random_value
);

  localparam int PTR_W      = (STATE_WORDS > 1) ? $clog2(STATE_WORDS) : 1;
  localparam int WARM_STEPS = WARMUP_ROUNDS * STATE_WORDS;
  localparam int CNT_W      = $clog2(WARM_STEPS);
  localparam logic [PTR_W-1:0] IDX_LAST  = PTR_W'(STATE_WORDS - 1);
  localparam logic [PTR_W-1:0] PTR_LAG   = PTR_W'(LAG_SEPARATION);
  localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(WARM_STEPS - 1);

  ctl_t ctl;
  logic go;
  logic accept;
  logic out_free;

  upc_t upc_r, upc_nxt;
  logic seeded_r, seeded_nxt;
  logic pending_r, pending_nxt;
  logic [PTR_W-1:0] front_r, front_nxt;
  logic [PTR_W-1:0] rear_r, rear_nxt;
  logic [PTR_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [30:0] out_random_value_r, out_random_value_nxt;
  logic [31:0] seed_r, seed_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;

  logic [31:0] seed_eff;
  logic [30:0] fold_val;
  logic [30:0] mul_in;
  logic [31:0] sum;
  logic [31:0] rd_front;
  logic [31:0] rd_rear;
  logic              ram_we;
  logic [PTR_W-1:0]  ram_waddr;
  logic [31:0]       ram_wdata;

  // Word store
  alfr_ram #(
    .WIDTH (32),
    .DEPTH (STATE_WORDS)
  ) u_word_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (front_r),
    .rdata_a (rd_front),
    .raddr_b (rear_r),
    .rdata_b (rd_rear)
  );

  // Datapath values
  assign seed_eff = (seed_r == '0) ? 32'd1 : seed_r;
  assign fold_val = pm_fold(prod_r);
  assign mul_in   = pm_prep(acc_r);
  assign sum      = rd_front + rd_rear;

  // Fetch control word and pick next step
  always_comb begin
    ctl      = ucode(upc_r);
    accept   = in_valid && ctl.take_in;
    out_free = !out_valid_r || out_ready;
    go       = 1'b1;
    upc_nxt  = upc_r + 4'd1;
    unique case (ctl.seq)
      SQ_NEXT: begin
        upc_nxt = upc_r + 4'd1;
      end
      SQ_JUMP: begin
        upc_nxt = ctl.target;
      end
      SQ_DISPATCH: begin
        go = accept;
        if (!accept) begin
          upc_nxt = upc_r;
        end else if (in_operation == OP_DRAW && seeded_r) begin
          upc_nxt = ctl.target;
        end
      end
      SQ_LOOP_IDX: begin
        if (idx_r != IDX_LAST) begin
          upc_nxt = ctl.target;
        end
      end
      SQ_LOOP_CNT: begin
        if (cnt_r != CNT_LAST) begin
          upc_nxt = ctl.target;
        end
      end
      SQ_PEND: begin
        if (!pending_r) begin
          upc_nxt = ctl.target;
        end
      end
      SQ_WAIT_OUT: begin
        go      = out_free;
        upc_nxt = out_free ? ctl.target : upc_r;
      end
      default: begin
        upc_nxt = UA_IDLE;
      end
    endcase
  end

  // Word store write port
  always_comb begin
    ram_we    = go && (ctl.wsrc != WS_NONE);
    ram_waddr = front_r;
    ram_wdata = sum;
    unique case (ctl.wsrc)
      WS_SEED: begin
        ram_waddr = '0;
        ram_wdata = seed_eff;
      end
      WS_FOLD: begin
        ram_waddr = idx_r;
        ram_wdata = {1'b0, fold_val};
      end
      WS_SUM: begin
        ram_waddr = front_r;
        ram_wdata = sum;
      end
      default: begin
        ram_waddr = front_r;
        ram_wdata = sum;
      end
    endcase
  end

  // Next values of counters, pointers and payload registers
  always_comb begin
    seeded_nxt           = seeded_r;
    pending_nxt          = pending_r;
    front_nxt            = front_r;
    rear_nxt             = rear_r;
    idx_nxt              = idx_r;
    cnt_nxt              = cnt_r;
    seed_nxt             = seed_r;
    acc_nxt              = acc_r;
    prod_nxt             = prod_r;
    out_random_value_nxt = out_random_value_r;
    out_valid_nxt        = out_valid_r && !out_ready;

    // latch the item; an unseeded draw seeds with one first
    if (ctl.take_in && accept) begin
      pending_nxt = (in_operation == OP_DRAW);
      seed_nxt    = (in_operation == OP_DRAW) ? 32'd1 : in_seed_value;
    end
    if (ctl.wsrc == WS_SEED) begin
      acc_nxt = seed_eff;
    end
    if (ctl.wsrc == WS_FOLD) begin
      acc_nxt = {1'b0, fold_val};
    end
    if (ctl.mul_en) begin
      prod_nxt = PROD_W'(PM_MULT) * PROD_W'(mul_in);
    end
    if (ctl.idx_set) begin
      idx_nxt = PTR_W'(1);
    end
    if (ctl.idx_inc) begin
      idx_nxt = idx_r + PTR_W'(1);
    end
    if (ctl.ptr_init) begin
      front_nxt = PTR_LAG;
      rear_nxt  = '0;
    end
    // advance both indices with wrap
    if (ctl.ptr_adv && go) begin
      front_nxt = (front_r == IDX_LAST) ? '0 : front_r + PTR_W'(1);
      rear_nxt  = (rear_r == IDX_LAST) ? '0 : rear_r + PTR_W'(1);
    end
    if (ctl.cnt_clr) begin
      cnt_nxt = '0;
    end
    if (ctl.cnt_inc) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end
    if (ctl.set_seeded) begin
      seeded_nxt = 1'b1;
    end
    // load the result beat
    if (ctl.out_load && go) begin
      out_valid_nxt        = 1'b1;
      out_random_value_nxt = sum[31:1];
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r       <= UA_IDLE;
      seeded_r    <= 1'b0;
      pending_r   <= 1'b0;
      front_r     <= PTR_LAG;
      rear_r      <= '0;
      idx_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      upc_r       <= upc_nxt;
      seeded_r    <= seeded_nxt;
      pending_r   <= pending_nxt;
      front_r     <= front_nxt;
      rear_r      <= rear_nxt;
      idx_r       <= idx_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    seed_r             <= seed_nxt;
    acc_r              <= acc_nxt;
    prod_r             <= prod_nxt;
    out_random_value_r <= out_random_value_nxt;
  end

  assign in_ready         = ctl.take_in;
  assign out_valid        = out_valid_r;
  assign out_random_value = out_random_value_r;

`ifndef SYNTHESIS
  localparam int SP_W = PTR_W + 2;

  // A result beat appears only from the draw step
  a_out_from_draw: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(upc_r == UA_DRAW_ADD))
    else $error("result beat raised outside the draw step");

  // Front leads rear by the lag, modulo the store depth
  a_lag_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    (SP_W'(front_r) == SP_W'(rear_r) + SP_W'(LAG_SEPARATION)) ||
    (SP_W'(front_r) + SP_W'(STATE_WORDS) == SP_W'(rear_r) + SP_W'(LAG_SEPARATION)))
    else $error("front and rear indices lost their spacing");

  // Indices stay inside the store
  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (front_r <= IDX_LAST) && (rear_r <= IDX_LAST))
    else $error("index beyond the word store");

  // An unseeded draw starts the seed program and keeps the draw pending
  a_unseeded_draw: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_operation == OP_DRAW && !seeded_r)
    |=> (upc_r == UA_SEED_W0) && pending_r)
    else $error("unseeded draw did not start seeding");

  // Once seeded, the generator stays seeded
  a_seeded_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    !$fell(seeded_r))
    else $error("seeded flag dropped");
`endif

endmodule

`default_nettype wire
